/* src/ssmf_pkg.sv */
// Shared constants and controller/datapath interface types for the mode finder.
package ssmf_pkg;

    localparam int MAX_POINTS = 8;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int OUT_CNT_W  = 4;
    localparam int OUT_CNT_MAX = 15;
    localparam int SAT_W      = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

    typedef struct packed {
        logic load;       // store the incoming word
        logic scan_init;  // reset scan index and best-so-far count
        logic scan_step;  // evaluate one candidate, advance index
        logic finish;     // clear fill count and overflow flag
    } ssmf_cmd_t;

    typedef struct packed {
        logic scan_last;  // current candidate is the last stored word
    } ssmf_status_t;

endpackage

/* src/ssmf_datapath.sv */
// Datapath: value store, fill/overflow tracking, count pass and best-so-far registers.
module ssmf_datapath
    import ssmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssmf_cmd_t            cmd,
    output ssmf_status_t         status,
    input  logic [31:0]          label_value,
    output logic [31:0]          mode_value,
    output logic [OUT_CNT_W-1:0] mode_count,
    output logic                 overflowed
);

    logic [31:0]      store_reg [MAX_POINTS];
    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic             overflow_reg, overflow_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] best_cnt_reg, best_cnt_next;
    logic [31:0]      best_val_reg, best_val_next;

    logic [31:0]         cand;
    logic [MAX_POINTS-1:0] match;
    logic [CNT_W-1:0]    cand_cnt;
    logic                full;
    logic [SAT_W-1:0]    cnt_wide;

    assign full = (fill_count_reg == CNT_W'(MAX_POINTS));
    assign cand = store_reg[idx_reg];

    always_comb
    begin
        for (int j = 0; j < MAX_POINTS; j++)
        begin
            match[j] = (IDX_W'(j) >= idx_reg) && (CNT_W'(j) < fill_count_reg)
                       && (store_reg[j] == cand);
        end
    end

    assign cand_cnt = CNT_W'($countones(match));
    assign status.scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_count_reg);

    always_comb
    begin
        fill_count_next = fill_count_reg;
        overflow_next   = overflow_reg;
        idx_next        = idx_reg;
        best_cnt_next   = best_cnt_reg;
        best_val_next   = best_val_reg;
        if (cmd.load)
        begin
            if (full)
                overflow_next = 1'b1;
            else
                fill_count_next = fill_count_reg + CNT_W'(1);
        end
        if (cmd.scan_init)
        begin
            idx_next      = '0;
            best_cnt_next = '0;
        end
        if (cmd.scan_step)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (cand_cnt > best_cnt_reg)
            begin
                best_cnt_next = cand_cnt;
                best_val_next = cand;
            end
        end
        if (cmd.finish)
        begin
            fill_count_next = '0;
            overflow_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            overflow_reg   <= 1'b0;
            idx_reg        <= '0;
            best_cnt_reg   <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            overflow_reg   <= overflow_next;
            idx_reg        <= idx_next;
            best_cnt_reg   <= best_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_val_reg <= best_val_next;
        if (cmd.load && !full)
            store_reg[fill_count_reg[IDX_W-1:0]] <= label_value;
    end

    assign cnt_wide   = SAT_W'(best_cnt_reg);
    assign mode_value = best_val_reg;
    assign mode_count = (cnt_wide > SAT_W'(OUT_CNT_MAX)) ? OUT_CNT_W'(OUT_CNT_MAX)
                                                         : cnt_wide[OUT_CNT_W-1:0];
    assign overflowed = overflow_reg;

endmodule

/* src/ssmf_ctrl.sv */
// Controller: load / count-pass / emit sequencing for the mode finder.
module ssmf_ctrl
    import ssmf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         last_value,
    input  ssmf_status_t status,
    output ssmf_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.load      = accept;
        cmd.scan_init = accept && last_value;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_value)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_EMIT);

endmodule

/* src/small_set_mode_finder_top.sv */
// Top level of the small-set mode finder.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+---------------------------
//  input   | label_value[31:0], last_value            | taken when start && !busy
//  result  | mode_value[31:0], mode_count[3:0],       | valid one cycle with done
//          | overflowed                               |
//
// A word without last_value is taken while idle; busy stays low.
// A word with last_value starts the count pass, which takes each stored word
// (1..MAX_POINTS) in turn as the candidate, then an emit state with done high.
// The count pass compares one candidate per cycle with words from its index on.
// rst_n clears fill count, overflow flag and controller state.
// overflowed clears after done; done lasts one cycle; the receiver cannot stall.
module small_set_mode_finder_top
    import ssmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          label_value,
    input  logic                 last_value,
    output logic                 done,
    output logic [31:0]          mode_value,
    output logic [OUT_CNT_W-1:0] mode_count,
    output logic                 overflowed
);

    ssmf_cmd_t    cmd;
    ssmf_status_t status;

    ssmf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_value (last_value),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    ssmf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .label_value (label_value),
        .mode_value  (mode_value),
        .mode_count  (mode_count),
        .overflowed  (overflowed)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_value) |=> busy)
        else $error("last word did not start the count pass");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (mode_count != '0))
        else $error("result with zero count");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("not idle after result");

endmodule
